[hdl/pfe_pkg.sv]
// Shared types, constants and cell arithmetic for the Playfair digraph encryptor.
// No dependencies; imported by pfe_front, pfe_back and playfair_digraph_encrypt.
`default_nettype none
package pfe_pkg;

  localparam int GRID_SIDE   = 5;
  localparam int CELLS       = GRID_SIDE * GRID_SIDE;
  localparam int ALPHA       = 26;
  localparam int LW          = 5;
  localparam int CW          = $clog2(CELLS);
  localparam int FW          = $clog2(CELLS + 1);
  localparam int PW          = $clog2(GRID_SIDE);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPW         = $clog2(QUEUE_DEPTH);
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

  typedef logic [1:0]    mode_t;
  typedef logic [LW-1:0] letter_t;
  typedef logic [CW-1:0] cell_t;
  typedef logic [FW-1:0] fill_t;
  typedef logic [PW-1:0] pos_t;

  localparam mode_t MODE_CLEAR   = 2'd0;
  localparam mode_t MODE_KEY     = 2'd1;
  localparam mode_t MODE_FILL    = 2'd2;
  localparam mode_t MODE_ENCRYPT = 2'd3;

  localparam letter_t LETTER_I = letter_t'(8);
  localparam letter_t LETTER_J = letter_t'(9);
  localparam letter_t LETTER_Z = letter_t'(ALPHA - 1);

  localparam fill_t FILL_FULL = fill_t'(CELLS);

  typedef struct packed {
    mode_t   mode;
    letter_t first;
    letter_t second;
    logic    key_ok;
  } cmd_t;

  typedef struct packed {
    logic  key_ready;
    fill_t fill_count;
  } stat_t;

  function automatic letter_t norm_letter(input letter_t v);
    letter_t l;
    l = (v > LETTER_Z) ? LETTER_Z : v;
    return (l == LETTER_J) ? LETTER_I : l;
  endfunction

  function automatic pos_t cell_row(input cell_t c);
    pos_t r;
    r = '0;
    for (int i = 1; i < GRID_SIDE; i++) begin
      if (c >= cell_t'(i * GRID_SIDE)) begin
        r = pos_t'(i);
      end
    end
    return r;
  endfunction

  function automatic pos_t cell_col(input cell_t c);
    cell_t base;
    base = cell_t'(cell_row(c) * GRID_SIDE);
    return pos_t'(c - base);
  endfunction

  function automatic cell_t cell_at(input pos_t r, input pos_t k);
    return cell_t'(r * GRID_SIDE + k);
  endfunction

  function automatic pos_t pos_next(input pos_t p);
    return (p == pos_t'(GRID_SIDE - 1)) ? '0 : pos_t'(p + 1'b1);
  endfunction

endpackage
`default_nettype wire

[hdl/pfe_front.sv]
// Front end: takes transactions on the command port, classifies them and queues them.
// Depends on pfe_pkg.
`default_nettype none
module pfe_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  pfe_pkg::mode_t       in_mode,
  input  pfe_pkg::letter_t     in_first_letter,
  input  pfe_pkg::letter_t     in_second_letter,
  output pfe_pkg::cmd_t        head,
  output logic                 head_valid,
  input  wire                  pop
);
  import pfe_pkg::*;

  cmd_t                 slot_r [QUEUE_DEPTH];
  logic [QPW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]       count_r, count_nxt;
  logic                 accept;
  cmd_t                 cls;

  assign busy       = (count_r == QCW'(QUEUE_DEPTH));
  assign accept     = start && !busy;
  assign head       = slot_r[rd_ptr_r];
  assign head_valid = (count_r != '0);

  always_comb begin
    cls.mode   = in_mode;
    cls.first  = (in_mode == MODE_ENCRYPT) ? norm_letter(in_first_letter) : in_first_letter;
    cls.second = norm_letter(in_second_letter);
    cls.key_ok = (in_first_letter <= LETTER_Z) && (in_first_letter != LETTER_J);
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (accept) begin
      wr_ptr_nxt = (wr_ptr_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : QPW'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : QPW'(rd_ptr_r + 1'b1);
    end
    case ({accept, pop})
      2'b10:   count_nxt = QCW'(count_r + 1'b1);
      2'b01:   count_nxt = QCW'(count_r - 1'b1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

[hdl/pfe_back.sv]
// Back end: key square builder and digraph encryptor with grid and cell-of-letter memories.
// Depends on pfe_pkg; fed by pfe_front.
`default_nettype none
module pfe_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  pfe_pkg::cmd_t        head,
  input  wire                  head_valid,
  output logic                 pop,
  output pfe_pkg::stat_t       stat,
  output logic                 out_strobe,
  output pfe_pkg::letter_t     out_first_out,
  output pfe_pkg::letter_t     out_second_out,
  output logic                 out_status
);
  import pfe_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ENC  = 2'd1;
  localparam logic [1:0] ST_FILL = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [ALPHA-1:0] used_r, used_nxt;
  fill_t            fill_r, fill_nxt;
  logic             key_ready_r, key_ready_nxt;
  letter_t          walk_r, walk_nxt;
  logic             enc_ok_r, enc_ok_nxt;
  logic             strobe_r, strobe_nxt;
  logic             status_r, status_nxt;

  letter_t          grid_mem [CELLS];
  cell_t            cell_mem [ALPHA];
  cell_t            cell_rd1_r, cell_rd2_r;
  letter_t          grid_rd1_r, grid_rd2_r;

  logic             place_en;
  letter_t          place_letter;
  pos_t             r1, k1, r2, k2;
  cell_t            o1, o2;

  assign pop = head_valid && (state_r == ST_IDLE);

  always_comb begin
    place_en     = 1'b0;
    place_letter = head.first;
    if (state_r == ST_FILL) begin
      place_letter = walk_r;
      place_en     = (walk_r != LETTER_J) && !used_r[walk_r] && (fill_r < FILL_FULL);
    end else if (pop && (head.mode == MODE_KEY)) begin
      place_en = !key_ready_r && head.key_ok && !used_r[head.first] && (fill_r < FILL_FULL);
    end
  end

  always_comb begin
    r1 = cell_row(cell_rd1_r);
    k1 = cell_col(cell_rd1_r);
    r2 = cell_row(cell_rd2_r);
    k2 = cell_col(cell_rd2_r);
    if (r1 == r2) begin
      o1 = cell_at(r1, pos_next(k1));
      o2 = cell_at(r2, pos_next(k2));
    end else if (k1 == k2) begin
      o1 = cell_at(pos_next(r1), k1);
      o2 = cell_at(pos_next(r2), k2);
    end else begin
      o1 = cell_at(r1, k2);
      o2 = cell_at(r2, k1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    fill_nxt      = fill_r;
    key_ready_nxt = key_ready_r;
    walk_nxt      = walk_r;
    enc_ok_nxt    = enc_ok_r;
    strobe_nxt    = 1'b0;
    status_nxt    = status_r;
    if (place_en) begin
      used_nxt[place_letter] = 1'b1;
      fill_nxt               = fill_t'(fill_r + 1'b1);
    end
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          case (head.mode)
            MODE_CLEAR: begin
              used_nxt      = '0;
              fill_nxt      = '0;
              key_ready_nxt = 1'b0;
            end
            MODE_FILL: begin
              if (!key_ready_r) begin
                state_nxt = ST_FILL;
                walk_nxt  = '0;
              end
            end
            MODE_ENCRYPT: begin
              state_nxt  = ST_ENC;
              enc_ok_nxt = key_ready_r;
            end
            default: ;
          endcase
        end
      end
      ST_ENC: begin
        state_nxt  = ST_IDLE;
        strobe_nxt = 1'b1;
        status_nxt = !enc_ok_r;
      end
      ST_FILL: begin
        if (walk_r == LETTER_Z) begin
          key_ready_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          walk_nxt = letter_t'(walk_r + 1'b1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      fill_r      <= '0;
      key_ready_r <= 1'b0;
      strobe_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      fill_r      <= fill_nxt;
      key_ready_r <= key_ready_nxt;
      strobe_r    <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_r   <= walk_nxt;
    enc_ok_r <= enc_ok_nxt;
    status_r <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (place_en) begin
      grid_mem[fill_r[CW-1:0]] <= place_letter;
      cell_mem[place_letter]   <= fill_r[CW-1:0];
    end
    if (pop && (head.mode == MODE_ENCRYPT)) begin
      cell_rd1_r <= cell_mem[head.first];
      cell_rd2_r <= cell_mem[head.second];
    end
    if (state_r == ST_ENC) begin
      grid_rd1_r <= grid_mem[o1];
      grid_rd2_r <= grid_mem[o2];
    end
  end

  assign stat.key_ready  = key_ready_r;
  assign stat.fill_count = fill_r;

  assign out_strobe     = strobe_r;
  assign out_status     = status_r;
  assign out_first_out  = status_r ? '0 : grid_rd1_r;
  assign out_second_out = status_r ? '0 : grid_rd2_r;

endmodule
`default_nettype wire

[hdl/playfair_digraph_encrypt.sv]
// Playfair digraph encryptor top level: command queue front end and key square back end.
// A digraph passes the queue stage, the cell-of-letter read and the grid read, in that order,
// before its result strobe. The back end takes one key letter per cycle while it is idle; it
// takes no new command during a digraph or a finish fill, which walks the alphabet letter by
// letter. busy rises when the two-entry queue is full. Results cannot be stalled.
// Synchronous reset empties the queue and clears the key state; no memory clearing pass.
`default_nettype none
module playfair_digraph_encrypt (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  pfe_pkg::mode_t       in_mode,
  input  pfe_pkg::letter_t     in_first_letter,
  input  pfe_pkg::letter_t     in_second_letter,
  output logic                 out_strobe,
  output pfe_pkg::letter_t     out_first_out,
  output pfe_pkg::letter_t     out_second_out,
  output logic                 out_status
);
  import pfe_pkg::*;

  cmd_t  head;
  logic  head_valid;
  logic  pop;
  stat_t stat;

  pfe_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_first_letter  (in_first_letter),
    .in_second_letter (in_second_letter),
    .head             (head),
    .head_valid       (head_valid),
    .pop              (pop)
  );

  pfe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .head_valid     (head_valid),
    .pop            (pop),
    .stat           (stat),
    .out_strobe     (out_strobe),
    .out_first_out  (out_first_out),
    .out_second_out (out_second_out),
    .out_status     (out_status)
  );

`ifndef SYNTH
  a_strobe_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe on consecutive cycles");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    stat.key_ready |-> (stat.fill_count == FILL_FULL))
    else $error("key square marked ready but not full");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_strobe))
    else $error("busy or strobe after reset");
`endif

endmodule
`default_nettype wire
